// ===== design/tsphk_pkg.sv =====
`default_nettype none
package tsphk_pkg;

  localparam int IN_W    = 16;
  localparam int COST_W  = 26;
  localparam int CNT_W   = 5;
  localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

  typedef struct packed {
    logic store;
    logic last;
    logic too_many;
  } tsphk_ctl_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_D_RD,
    S_D_SUB,
    S_D_MUL,
    S_D_LOAD,
    S_D_SQ,
    S_D_WR,
    S_P_J,
    S_P_INIT,
    S_P_K,
    S_P_ACC,
    S_P_WR,
    S_F_RD,
    S_F_ACC,
    S_OUT
  } tsphk_state_t;

endpackage
`default_nettype wire

// ===== design/tsphk_ram.sv =====
`default_nettype none
module tsphk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/tsphk_front.sv =====
`default_nettype none
module tsphk_front #(
  parameter int MAX_CITIES = 16,
  parameter int COORD_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [tsphk_pkg::IN_W-1:0] in_x_coord,
  input  wire logic signed [tsphk_pkg::IN_W-1:0] in_y_coord,
  input  wire logic                              in_last_point,
  output logic                                   q_valid,
  input  wire logic                              q_pop,
  output logic signed [COORD_BITS-1:0]           q_x,
  output logic signed [COORD_BITS-1:0]           q_y,
  output logic [$clog2(MAX_CITIES)-1:0]          q_slot,
  output logic [$clog2(MAX_CITIES+1)-1:0]        q_cnt,
  output tsphk_pkg::tsphk_ctl_t                  q_ctl
);
  import tsphk_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int CIW = $clog2(MAX_CITIES);
  localparam int CW  = $clog2(MAX_CITIES+1);

  logic [CW-1:0]  cnt_r;
  logic           ovf_r;
  logic           push;
  logic           store;
  logic signed [CB-1:0] x_ext;
  logic signed [CB-1:0] y_ext;

  logic signed [CB-1:0] qx_r   [2];
  logic signed [CB-1:0] qy_r   [2];
  logic [CIW-1:0]       qs_r   [2];
  logic [CW-1:0]        qc_r   [2];
  tsphk_ctl_t           qctl_r [2];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           fill_r;

  generate
    if (CB <= IN_W) begin : g_narrow
      assign x_ext = in_x_coord[CB-1:0];
      assign y_ext = in_y_coord[CB-1:0];
    end else begin : g_wide
      assign x_ext = {{(CB-IN_W){1'b0}}, in_x_coord};
      assign y_ext = {{(CB-IN_W){1'b0}}, in_y_coord};
    end
  endgenerate

  assign in_stall = (fill_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign store    = (cnt_r < CW'(MAX_CITIES));
  assign q_valid  = (fill_r != 2'd0);
  assign q_x      = qx_r[rd_ptr_r];
  assign q_y      = qy_r[rd_ptr_r];
  assign q_slot   = qs_r[rd_ptr_r];
  assign q_cnt    = qc_r[rd_ptr_r];
  assign q_ctl    = qctl_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        qx_r[wr_ptr_r]            <= x_ext;
        qy_r[wr_ptr_r]            <= y_ext;
        qs_r[wr_ptr_r]            <= cnt_r[CIW-1:0];
        qc_r[wr_ptr_r]            <= store ? cnt_r + CW'(1) : cnt_r;
        qctl_r[wr_ptr_r].store    <= store;
        qctl_r[wr_ptr_r].last     <= in_last_point;
        qctl_r[wr_ptr_r].too_many <= ovf_r || !store;
        wr_ptr_r <= !wr_ptr_r;
        // start a fresh set after the closing point
        if (in_last_point) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          if (store) begin
            cnt_r <= cnt_r + CW'(1);
          end
          ovf_r <= ovf_r || !store;
        end
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !q_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (!push && q_pop) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/tsphk_back.sv =====
`default_nettype none
module tsphk_back #(
  parameter int MAX_CITIES = 16,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  output logic                                     q_pop,
  input  wire logic signed [COORD_BITS-1:0]        q_x,
  input  wire logic signed [COORD_BITS-1:0]        q_y,
  input  wire logic [$clog2(MAX_CITIES)-1:0]       q_slot,
  input  wire logic [$clog2(MAX_CITIES+1)-1:0]     q_cnt,
  input  wire tsphk_pkg::tsphk_ctl_t               q_ctl,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tsphk_pkg::COST_W-1:0]             out_tour_cost,
  output logic [tsphk_pkg::CNT_W-1:0]              out_city_count,
  output logic                                     out_saturated,
  output logic                                     out_too_many
);
  import tsphk_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int CIW  = $clog2(MAX_CITIES);
  localparam int CW   = $clog2(MAX_CITIES+1);
  localparam int MW   = MAX_CITIES - 1;
  localparam int DW   = CB + 5;
  localparam int RW   = 2*CB + 10;
  localparam int SW   = CB + 5;
  localparam int SQW  = $clog2(SW+1);
  localparam int SUMW = ((DW > COST_W) ? DW : COST_W) + 1;
  localparam int DAW  = 2*CIW;
  localparam int SAW  = MW + CIW;

  tsphk_state_t state_r, state_nxt;

  logic [CIW-1:0]  i_r, j_r, k_r;
  logic [CW-1:0]   n_r;
  logic            ovf_r;
  logic [MW-1:0]   mask_r;
  logic [COST_W-1:0] m_r;
  logic            sat_r;
  logic signed [CB:0]   dx_r, dy_r;
  logic [2*CB:0]   sqx_r, sqy_r;
  logic [RW-1:0]   rad_r;
  logic [SW+1:0]   rem_r;
  logic [SW-1:0]   root_r;
  logic [SQW-1:0]  sq_cnt_r;
  logic            out_valid_r;
  logic [COST_W-1:0] out_cost_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic            out_sat_r;
  logic            out_many_r;

  logic [2*CB-1:0] pa_rd, pb_rd;
  logic            pt_we;
  logic [DW-1:0]   dist_rd;
  logic            dist_we;
  logic [DAW-1:0]  dist_waddr, dist_raddr;
  logic [COST_W-1:0] sub_rd;
  logic            sub_we;
  logic [SAW-1:0]  sub_waddr, sub_raddr;

  logic [CIW-1:0]  last_n, last_o;
  logic [MW:0]     one_sh;
  logic [MW-1:0]   full;
  logic [MW-1:0]   rest;
  logic            j_bit, k_bit, j_end;
  logic signed [2*CB+1:0] prod_x, prod_y;
  logic [SW+3:0]   rem_sh, trial;
  logic [COST_W-1:0] add_a;
  logic [SUMW-1:0] sum;
  logic            sum_sat;
  logic [COST_W-1:0] sum_c;
  logic            out_free;

  tsphk_ram #(.WIDTH(2*CB), .DEPTH(MAX_CITIES)) u_pts_a (
    .clk(clk), .we(pt_we), .waddr(q_slot), .wdata({q_x, q_y}),
    .raddr(i_r), .rdata(pa_rd)
  );

  tsphk_ram #(.WIDTH(2*CB), .DEPTH(MAX_CITIES)) u_pts_b (
    .clk(clk), .we(pt_we), .waddr(q_slot), .wdata({q_x, q_y}),
    .raddr(j_r), .rdata(pb_rd)
  );

  tsphk_ram #(.WIDTH(DW), .DEPTH(1 << DAW)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(root_r),
    .raddr(dist_raddr), .rdata(dist_rd)
  );

  tsphk_ram #(.WIDTH(COST_W), .DEPTH(1 << SAW)) u_sub (
    .clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(m_r),
    .raddr(sub_raddr), .rdata(sub_rd)
  );

  assign last_n  = CIW'(n_r - CW'(1));
  assign last_o  = CIW'(n_r - CW'(2));
  assign one_sh  = (MW+1)'(1) << (n_r - CW'(1));
  assign full    = MW'(one_sh - (MW+1)'(1));
  assign rest    = mask_r & ~(MW'(1) << j_r);
  assign j_bit   = |(mask_r & (MW'(1) << j_r));
  assign k_bit   = |(rest & (MW'(1) << k_r));
  assign j_end   = (j_r == last_o);
  assign prod_x  = dx_r * dx_r;
  assign prod_y  = dy_r * dy_r;
  assign rem_sh  = {rem_r, rad_r[RW-1:RW-2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign add_a   = (state_r == S_P_INIT) ? '0 : sub_rd;
  assign sum     = SUMW'(add_a) + SUMW'(dist_rd);
  assign sum_sat = (sum >= SUMW'(COST_INF));
  assign sum_c   = sum_sat ? COST_INF : sum[COST_W-1:0];
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_tour_cost  = out_cost_r;
  assign out_city_count = out_cnt_r;
  assign out_saturated  = out_sat_r;
  assign out_too_many   = out_many_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (q_valid && q_ctl.last) begin
          state_nxt = (q_cnt == CW'(1)) ? S_OUT : S_D_RD;
        end
      end
      S_D_RD:   state_nxt = S_D_SUB;
      S_D_SUB:  state_nxt = S_D_MUL;
      S_D_MUL:  state_nxt = S_D_LOAD;
      S_D_LOAD: state_nxt = S_D_SQ;
      S_D_SQ: begin
        if (sq_cnt_r == SQW'(SW-1)) begin
          state_nxt = S_D_WR;
        end
      end
      S_D_WR: begin
        state_nxt = (i_r == last_n && j_r == last_n) ? S_P_J : S_D_RD;
      end
      S_P_J: begin
        if (!j_bit) begin
          state_nxt = (j_end && mask_r == full) ? S_F_RD : S_P_J;
        end else if (rest == '0) begin
          state_nxt = S_P_INIT;
        end else begin
          state_nxt = S_P_K;
        end
      end
      S_P_INIT: state_nxt = S_P_WR;
      S_P_K: begin
        if (k_bit) begin
          state_nxt = S_P_ACC;
        end else if (k_r == last_o) begin
          state_nxt = S_P_WR;
        end
      end
      S_P_ACC: state_nxt = (k_r == last_o) ? S_P_WR : S_P_K;
      S_P_WR:  state_nxt = (j_end && mask_r == full) ? S_F_RD : S_P_J;
      S_F_RD:  state_nxt = S_F_ACC;
      S_F_ACC: state_nxt = j_end ? S_OUT : S_F_RD;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    q_pop      = (state_r == S_LOAD) && q_valid;
    pt_we      = q_pop && q_ctl.store;
    dist_we    = (state_r == S_D_WR);
    dist_waddr = {i_r, j_r};
    sub_we     = (state_r == S_P_WR);
    sub_waddr  = {mask_r, j_r};
    sub_raddr  = {rest, k_r};
    case (state_r)
      S_P_J:   dist_raddr = {CIW'(0), CIW'(j_r + 1'b1)};
      S_P_K:   dist_raddr = {CIW'(k_r + 1'b1), CIW'(j_r + 1'b1)};
      S_F_RD: begin
        dist_raddr = {CIW'(j_r + 1'b1), CIW'(0)};
        sub_raddr  = {mask_r, j_r};
      end
      default: dist_raddr = {i_r, j_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      n_r         <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (q_valid && q_ctl.last) begin
            n_r   <= q_cnt;
            ovf_r <= q_ctl.too_many;
            i_r   <= '0;
            j_r   <= '0;
            sat_r <= 1'b0;
            m_r   <= '0;
          end
        end
        S_D_SUB: begin
          dx_r <= {pa_rd[2*CB-1], pa_rd[2*CB-1:CB]} - {pb_rd[2*CB-1], pb_rd[2*CB-1:CB]};
          dy_r <= {pa_rd[CB-1], pa_rd[CB-1:0]} - {pb_rd[CB-1], pb_rd[CB-1:0]};
        end
        S_D_MUL: begin
          sqx_r <= prod_x[2*CB:0];
          sqy_r <= prod_y[2*CB:0];
        end
        S_D_LOAD: begin
          rad_r    <= {(2*CB+2)'(sqx_r) + (2*CB+2)'(sqy_r), 8'b0};
          rem_r    <= '0;
          root_r   <= '0;
          sq_cnt_r <= '0;
        end
        S_D_SQ: begin
          // one root bit per cycle, restoring
          if (rem_sh >= trial) begin
            rem_r  <= (SW+2)'(rem_sh - trial);
            root_r <= {root_r[SW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[SW+1:0];
            root_r <= {root_r[SW-2:0], 1'b0};
          end
          rad_r    <= rad_r << 2;
          sq_cnt_r <= sq_cnt_r + SQW'(1);
        end
        S_D_WR: begin
          if (j_r == last_n) begin
            j_r <= '0;
            i_r <= i_r + CIW'(1);
          end else begin
            j_r <= j_r + CIW'(1);
          end
          mask_r <= MW'(1);
        end
        S_P_J, S_P_WR: begin
          if (state_r == S_P_J && j_bit) begin
            m_r <= COST_INF;
            k_r <= '0;
          end else if (j_end) begin
            j_r <= '0;
            if (mask_r == full) begin
              m_r <= COST_INF;
            end else begin
              mask_r <= mask_r + MW'(1);
            end
          end else begin
            j_r <= j_r + CIW'(1);
          end
        end
        S_P_INIT: begin
          m_r   <= sum_c;
          sat_r <= sat_r || sum_sat;
        end
        S_P_K: begin
          if (!k_bit) begin
            k_r <= k_r + CIW'(1);
          end
        end
        S_P_ACC: begin
          if (sum_c < m_r) begin
            m_r <= sum_c;
          end
          sat_r <= sat_r || sum_sat;
          k_r   <= k_r + CIW'(1);
        end
        S_F_ACC: begin
          if (sum_c < m_r) begin
            m_r <= sum_c;
          end
          sat_r <= sat_r || sum_sat;
          j_r   <= j_r + CIW'(1);
        end
        S_OUT: begin
          if (out_free) begin
            out_cost_r  <= m_r;
            out_cnt_r   <= CNT_W'(n_r);
            out_sat_r   <= sat_r;
            out_many_r  <= ovf_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_acc_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_ACC) |-> $past(state_r == S_P_K))
    else $error("accumulate without a read issued");

  a_root_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_WR) |-> (sq_cnt_r == SQW'(SW)))
    else $error("distance written before root finished");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !q_pop)
    else $error("queue popped while solving");
`endif
endmodule
`default_nettype wire

// ===== design/tsp_held_karp_min_tour_cost.sv =====
// Minimum closed-tour cost (Held-Karp) over up to MAX_CITIES points. Points load one per
// cycle, unless in_stall is raised, through a two-entry request queue; the request with
// last_point set closes the set. The solver then builds the distance table with one
// square-root bit per cycle, and runs the subset program over the subset cost memory
// with one memory read pair per step, before the result is registered on the output.
// New points queue up (two deep) while it works. A single point gives cost 0; points
// beyond MAX_CITIES are dropped and flagged.
`default_nettype none
module tsp_held_karp_min_tour_cost #(
  parameter int MAX_CITIES = 16,
  parameter int COORD_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [tsphk_pkg::IN_W-1:0] in_x_coord,
  input  wire logic signed [tsphk_pkg::IN_W-1:0] in_y_coord,
  input  wire logic                              in_last_point,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tsphk_pkg::COST_W-1:0]           out_tour_cost,
  output logic [tsphk_pkg::CNT_W-1:0]            out_city_count,
  output logic                                   out_saturated,
  output logic                                   out_too_many
);
  import tsphk_pkg::*;

  logic                                 q_valid;
  logic                                 q_pop;
  logic signed [COORD_BITS-1:0]         q_x;
  logic signed [COORD_BITS-1:0]         q_y;
  logic [$clog2(MAX_CITIES)-1:0]        q_slot;
  logic [$clog2(MAX_CITIES+1)-1:0]      q_cnt;
  tsphk_ctl_t                           q_ctl;

  tsphk_front #(.MAX_CITIES(MAX_CITIES), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord), .in_last_point(in_last_point),
    .q_valid(q_valid), .q_pop(q_pop), .q_x(q_x), .q_y(q_y),
    .q_slot(q_slot), .q_cnt(q_cnt), .q_ctl(q_ctl)
  );

  tsphk_back #(.MAX_CITIES(MAX_CITIES), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_x(q_x), .q_y(q_y),
    .q_slot(q_slot), .q_cnt(q_cnt), .q_ctl(q_ctl),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tour_cost(out_tour_cost), .out_city_count(out_city_count),
    .out_saturated(out_saturated), .out_too_many(out_too_many)
  );
endmodule
`default_nettype wire
